@@ sv/tssb_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP send segment buffer package
// Command/status codes, field widths, command, queue and descriptor records.
// ----------------------------------------------------------------------------
package tssb_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int LEN_W = 21;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_COPY = 2'd1;
	localparam logic [1:0] CMD_DISCARD = 2'd2;
	localparam logic [1:0] CMD_SET_HEAD = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_REJECT = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_DUMMY = 3'd3;
	localparam logic [2:0] ST_WINDOW = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] seg_handle;
		logic [15:0] seg_len;
		logic [20:0] num_bytes;
		logic [31:0] seq_num;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] trim;
		logic [15:0] len;
	} desc_t;

endpackage

@@ sv/tssb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tssb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/tssb_front.sv @@
// ----------------------------------------------------------------------------
// TCP send segment buffer front end
// Accepts command transactions into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module tssb_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tssb_pkg::cmd_t push_cmd,
	input logic pop,
	output tssb_pkg::cmd_t head_cmd,
	output tssb_pkg::queue_stat_t stat
);
	import tssb_pkg::*;

	cmd_t ent_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign stat.valid = (cnt_q != 2'd0);
	assign stat.full = (cnt_q == 2'd2);
	assign head_cmd = ent_q[rp_q];
	assign do_push = push && !stat.full;
	assign do_pop = pop && stat.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

@@ sv/tssb_back.sv @@
// ----------------------------------------------------------------------------
// TCP send segment buffer engine
// Executes queued commands, walking the descriptor ring for copy and discard.
// ----------------------------------------------------------------------------
module tssb_back #(
	parameter int SEGMENTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [20:0] cfg_data,
	input tssb_pkg::queue_stat_t qstat,
	input tssb_pkg::cmd_t qcmd,
	output logic pop,
	output logic result_strobe,
	output logic [2:0] status,
	output logic [31:0] frag_handle,
	output logic [15:0] frag_offset,
	output logic [20:0] frag_len,
	output logic last,
	output logic [31:0] head_sequence,
	output logic [20:0] buffered_bytes,
	output logic [20:0] available_bytes
);
	import tssb_pkg::*;

	localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CW = $clog2(SEGMENTS + 1);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_USE = 2'd2;

	logic [1:0] st_q;
	logic [20:0] max_q;
	logic [31:0] head_q;
	logic [20:0] held_q;
	logic [IW-1:0] rptr_q;
	logic [IW-1:0] wptr_q;
	logic [CW-1:0] count_q;
	cmd_t c_q;
	logic [CW-1:0] k_q;
	logic [4:0] n_q;
	logic [20:0] rem_q;
	logic [31:0] off_q;
	logic [21:0] cum_q;

	logic [20:0] avail;
	logic [31:0] tail;
	logic [31:0] tail_gap;
	logic [20:0] size;
	logic [31:0] qoff;
	logic [IW:0] idx_sum;
	logic [IW-1:0] idx;
	logic [IW-1:0] rptr_inc;
	logic [IW-1:0] wptr_inc;
	desc_t rd;
	desc_t wd;
	logic we;
	logic [IW-1:0] waddr;
	logic [63:0] rdata;
	logic hit;
	logic [20:0] start;
	logic [20:0] seg_rest;
	logic [20:0] take;
	logic [CW-1:0] kn;
	logic walk_end;
	logic [21:0] cum_next;
	logic whole;
	logic [20:0] held_dis;
	logic [31:0] head_dis;

	assign avail = (max_q > held_q) ? (max_q - held_q) : 21'd0;
	assign tail = head_q + {11'd0, held_q};
	assign tail_gap = tail - qcmd.seq_num;
	assign size = (tail_gap < {11'd0, qcmd.num_bytes}) ? tail_gap[20:0] : qcmd.num_bytes;
	assign qoff = qcmd.seq_num - head_q;

	assign idx_sum = {1'b0, rptr_q} + k_q[IW:0];
	assign idx = (idx_sum >= (IW+1)'(SEGMENTS)) ? IW'(idx_sum - (IW+1)'(SEGMENTS))
		: idx_sum[IW-1:0];
	assign rptr_inc = (rptr_q == IW'(SEGMENTS - 1)) ? '0 : rptr_q + 1'b1;
	assign wptr_inc = (wptr_q == IW'(SEGMENTS - 1)) ? '0 : wptr_q + 1'b1;

	assign rd = desc_t'(rdata);
	assign hit = (cum_q + {6'd0, rd.len}) > {1'b0, off_q[20:0]};
	assign start = (off_q[20:0] > cum_q[20:0]) ? (off_q[20:0] - cum_q[20:0]) : 21'd0;
	assign seg_rest = {5'd0, rd.len} - start;
	assign take = (seg_rest > rem_q) ? rem_q : seg_rest;
	assign kn = k_q + 1'b1;
	assign walk_end = (kn >= count_q) || (hit && (rem_q == take))
		|| (hit && (n_q == 5'(MAX_RESULTS - 1)));
	assign cum_next = cum_q + {6'd0, rd.len};
	assign whole = off_q >= {16'd0, rd.len};
	assign held_dis = whole ? (held_q - {5'd0, rd.len}) : (held_q - off_q[20:0]);
	assign head_dis = whole ? (head_q + {16'd0, rd.len}) : (head_q + off_q);

	assign pop = (st_q == S_IDLE) && qstat.valid;

	always_comb begin
		we = 1'b0;
		waddr = wptr_q;
		wd.handle = qcmd.seg_handle;
		wd.trim = 16'd0;
		wd.len = qcmd.seg_len;
		if (pop && (qcmd.cmd == CMD_ADD) && ({5'd0, qcmd.seg_len} <= avail)
				&& (qcmd.seg_len != 16'd0) && (count_q != CW'(SEGMENTS))) begin
			we = 1'b1;
		end else if ((st_q == S_USE) && (c_q.cmd == CMD_DISCARD) && !whole) begin
			we = 1'b1;
			waddr = rptr_q;
			wd.handle = rd.handle;
			wd.trim = rd.trim + off_q[15:0];
			wd.len = rd.len - off_q[15:0];
		end
	end

	tssb_ram #(
		.WIDTH(64),
		.DEPTH(SEGMENTS)
	) u_desc (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wd),
		.raddr(idx),
		.rdata(rdata)
	);

	assign head_sequence = head_q;
	assign buffered_bytes = held_q;
	assign available_bytes = avail;

	always_ff @(posedge clk) begin
		if (pop) begin
			c_q <= qcmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			max_q <= 21'd32768;
			head_q <= '0;
			held_q <= '0;
			rptr_q <= '0;
			wptr_q <= '0;
			count_q <= '0;
			k_q <= '0;
			n_q <= '0;
			rem_q <= '0;
			off_q <= '0;
			cum_q <= '0;
			result_strobe <= 1'b0;
			status <= ST_OK;
			frag_handle <= '0;
			frag_offset <= '0;
			frag_len <= '0;
			last <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			case (st_q)
				S_IDLE: begin
					if (pop) begin
						status <= ST_OK;
						frag_handle <= '0;
						frag_offset <= '0;
						frag_len <= '0;
						last <= 1'b1;
						result_strobe <= 1'b1;
						k_q <= '0;
						n_q <= '0;
						cum_q <= '0;
						rem_q <= size;
						off_q <= qoff;
						case (qcmd.cmd)
							CMD_ADD: begin
								if ({5'd0, qcmd.seg_len} > avail) begin
									status <= ST_REJECT;
								end else if (qcmd.seg_len != 16'd0) begin
									if (count_q == CW'(SEGMENTS)) begin
										status <= ST_REJECT;
									end else begin
										wptr_q <= wptr_inc;
										count_q <= count_q + 1'b1;
										held_q <= held_q + {5'd0, qcmd.seg_len};
									end
								end
							end
							CMD_COPY: begin
								if (tail_gap[31]) begin
									status <= ST_WINDOW;
								end else if (size == 21'd0) begin
									status <= ST_EMPTY;
								end else if (count_q == '0) begin
									status <= ST_DUMMY;
									frag_len <= size;
								end else if (qoff > {11'd0, held_q}) begin
									status <= ST_WINDOW;
								end else begin
									result_strobe <= 1'b0;
									st_q <= S_READ;
								end
							end
							CMD_DISCARD: begin
								if ((qoff != 32'd0) && !qoff[31]) begin
									if (count_q == '0) begin
										head_q <= qcmd.seq_num;
									end else begin
										result_strobe <= 1'b0;
										st_q <= S_READ;
									end
								end
							end
							default: begin
								head_q <= qcmd.seq_num;
							end
						endcase
					end
				end
				S_READ: begin
					st_q <= S_USE;
				end
				S_USE: begin
					if (c_q.cmd == CMD_COPY) begin
						cum_q <= cum_next;
						k_q <= kn;
						if (hit) begin
							result_strobe <= 1'b1;
							status <= ST_OK;
							frag_handle <= rd.handle;
							frag_offset <= rd.trim + start[15:0];
							frag_len <= take;
							last <= walk_end;
							rem_q <= rem_q - take;
							n_q <= n_q + 1'b1;
						end else if (walk_end && (n_q == 5'd0)) begin
							result_strobe <= 1'b1;
							status <= ST_EMPTY;
							frag_handle <= '0;
							frag_offset <= '0;
							frag_len <= '0;
							last <= 1'b1;
						end
						st_q <= walk_end ? S_IDLE : S_READ;
					end else begin
						held_q <= held_dis;
						head_q <= head_dis;
						if (whole) begin
							off_q <= off_q - {16'd0, rd.len};
							rptr_q <= rptr_inc;
							count_q <= count_q - 1'b1;
						end
						if (!whole || (count_q == CW'(1)) || (off_q == {16'd0, rd.len})) begin
							if (held_dis == 21'd0) begin
								head_q <= c_q.seq_num;
							end
							result_strobe <= 1'b1;
							status <= ST_OK;
							frag_handle <= '0;
							frag_offset <= '0;
							frag_len <= '0;
							last <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_READ;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SEGMENTS))
		else $error("descriptor count exceeds ring size");
	a_held_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (held_q != 21'd0))
		else $error("descriptors held with zero buffered bytes");
	a_ring_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> (IW'(wptr_q - rptr_q) == IW'(count_q)))
		else $error("ring pointers disagree with count");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |-> (st_q == S_IDLE))
		else $error("final result while engine still walking");
`endif
endmodule

@@ sv/tcp_send_segment_buffer.sv @@
// ----------------------------------------------------------------------------
// TCP send segment buffer
// Ring of segment descriptors with a head sequence number and four commands.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; a
// two-entry queue lets up to two commands wait while the engine works. Add
// and set head are handled in the idle state of the engine, as are copy and
// discard that end without touching the ring. Copy and discard walk the ring
// in a read state and a use state per descriptor, for the registered RAM read.
// Each result is presented for one cycle on result_strobe and cannot be
// stalled; a copy gives up to sixteen fragments, and last marks the final
// result of a command. The descriptor RAM needs no clearing after reset.
module tcp_send_segment_buffer #(
	parameter int SEGMENTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [20:0] cfg_data,
	input logic start,
	output logic busy,
	input logic [1:0] cmd,
	input logic [31:0] seg_handle,
	input logic [15:0] seg_len,
	input logic [20:0] num_bytes,
	input logic [31:0] seq_num,
	output logic result_strobe,
	output logic [2:0] status,
	output logic [31:0] frag_handle,
	output logic [15:0] frag_offset,
	output logic [20:0] frag_len,
	output logic last,
	output logic [31:0] head_sequence,
	output logic [20:0] buffered_bytes,
	output logic [20:0] available_bytes
);
	import tssb_pkg::*;

	cmd_t in_cmd;
	cmd_t q_cmd;
	queue_stat_t q_stat;
	logic q_pop;

	assign in_cmd.cmd = cmd;
	assign in_cmd.seg_handle = seg_handle;
	assign in_cmd.seg_len = seg_len;
	assign in_cmd.num_bytes = num_bytes;
	assign in_cmd.seq_num = seq_num;
	assign busy = q_stat.full;

	tssb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(start),
		.push_cmd(in_cmd),
		.pop(q_pop),
		.head_cmd(q_cmd),
		.stat(q_stat)
	);

	tssb_back #(
		.SEGMENTS(SEGMENTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.qstat(q_stat),
		.qcmd(q_cmd),
		.pop(q_pop),
		.result_strobe(result_strobe),
		.status(status),
		.frag_handle(frag_handle),
		.frag_offset(frag_offset),
		.frag_len(frag_len),
		.last(last),
		.head_sequence(head_sequence),
		.buffered_bytes(buffered_bytes),
		.available_bytes(available_bytes)
	);
endmodule

@@ verif/tcp_send_segment_buffer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP send segment buffer testbench
// Drives add, copy, discard and set head commands with random gaps, predicts
// every result with an independent model of the descriptor ring and checks
// each strobed result field by field in order.
// ----------------------------------------------------------------------------
import tssb_pkg::*;

typedef struct {
	logic [2:0] status;
	logic [31:0] handle;
	logic [15:0] offset;
	logic [20:0] len;
	logic last;
	logic [31:0] head;
	logic [20:0] held;
	logic [20:0] avail;
} seg_result_t;

class segment_ring_scoreboard;
	bit [20:0] limit;
	bit [31:0] head_seq;
	bit [20:0] held;
	bit [31:0] ring_handle[16];
	bit [15:0] ring_trim[16];
	bit [15:0] ring_len[16];
	bit [3:0] rd_ptr;
	bit [3:0] wr_ptr;
	int count;
	seg_result_t pending[$];
	int errors;

	function new();
		limit = 21'd32768;
		head_seq = 0;
		held = 0;
		rd_ptr = 0;
		wr_ptr = 0;
		count = 0;
		errors = 0;
	endfunction

	function bit [20:0] room();
		return (limit > held) ? limit - held : 21'd0;
	endfunction

	function void push(logic [2:0] st, logic [31:0] h, logic [15:0] o, logic [20:0] l);
		seg_result_t r;
		r.status = st;
		r.handle = h;
		r.offset = o;
		r.len = l;
		r.last = 0;
		pending = {pending, r};
	endfunction

	function void predict_copy(bit [31:0] num, bit [31:0] seq);
		bit [31:0] tail_dist;
		bit [31:0] size;
		bit [31:0] offs;
		bit [31:0] cum;
		bit [31:0] remaining;
		bit [31:0] len;
		bit [31:0] from;
		bit [31:0] take;
		bit [3:0] idx;
		int n;
		tail_dist = head_seq + held - seq;
		cum = 0;
		n = 0;
		if (tail_dist[31]) begin
			push(ST_WINDOW, 0, 0, 0);
			return;
		end
		size = (num < tail_dist) ? num : tail_dist;
		if (size == 0) begin
			push(ST_EMPTY, 0, 0, 0);
			return;
		end
		if (count == 0) begin
			push(ST_DUMMY, 0, 0, size[20:0]);
			return;
		end
		offs = seq - head_seq;
		if (offs > held) begin
			push(ST_WINDOW, 0, 0, 0);
			return;
		end
		remaining = size;
		for (int k = 0; k < count && remaining > 0 && n < MAX_RESULTS; k++) begin
			idx = rd_ptr + k;
			len = ring_len[idx];
			if (cum + len > offs) begin
				from = (offs > cum) ? offs - cum : 0;
				take = len - from;
				if (take > remaining)
					take = remaining;
				push(ST_OK, ring_handle[idx], ring_trim[idx] + from[15:0], take[20:0]);
				n++;
				remaining -= take;
			end
			cum += len;
		end
		if (n == 0)
			push(ST_EMPTY, 0, 0, 0);
	endfunction

	function void predict_discard(bit [31:0] seq);
		bit [31:0] offs;
		bit [31:0] len;
		offs = seq - head_seq;
		if (offs == 0 || offs[31])
			return;
		while (count > 0 && offs > 0) begin
			len = ring_len[rd_ptr];
			if (offs >= len) begin
				held -= len;
				head_seq += len;
				offs -= len;
				rd_ptr++;
				count--;
			end else begin
				ring_trim[rd_ptr] += offs[15:0];
				ring_len[rd_ptr] = len - offs;
				held -= offs;
				head_seq += offs;
				offs = 0;
			end
		end
		if (held == 0)
			head_seq = seq;
	endfunction

	function void note_command(cmd_t c);
		int first;
		logic [2:0] st;
		first = pending.size();
		case (c.cmd)
			CMD_ADD: begin
				st = ST_OK;
				if (c.seg_len > room())
					st = ST_REJECT;
				else if (c.seg_len > 0) begin
					if (count >= 16)
						st = ST_REJECT;
					else begin
						ring_handle[wr_ptr] = c.seg_handle;
						ring_trim[wr_ptr] = 0;
						ring_len[wr_ptr] = c.seg_len;
						wr_ptr++;
						count++;
						held = held + c.seg_len;
					end
				end
				push(st, 0, 0, 0);
			end
			CMD_COPY: predict_copy(c.num_bytes, c.seq_num);
			CMD_DISCARD: begin
				predict_discard(c.seq_num);
				push(ST_OK, 0, 0, 0);
			end
			default: begin
				head_seq = c.seq_num;
				push(ST_OK, 0, 0, 0);
			end
		endcase
		for (int k = first; k < pending.size(); k++) begin
			pending[k].last = (k == pending.size() - 1);
			pending[k].head = head_seq;
			pending[k].held = held;
			pending[k].avail = room();
		end
	endfunction

	function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
				act_v);
		end
	endfunction

	function void check_result(seg_result_t act);
		seg_result_t e;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual status %0d", $time,
				act.status);
			return;
		end
		e = pending.pop_front();
		compare("status", e.status, act.status);
		compare("frag_handle", e.handle, act.handle);
		compare("frag_offset", e.offset, act.offset);
		compare("frag_len", e.len, act.len);
		compare("last", e.last, act.last);
		compare("head_sequence", e.head, act.head);
		compare("buffered_bytes", e.held, act.held);
		compare("available_bytes", e.avail, act.avail);
	endfunction
endclass

module tcp_send_segment_buffer_tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [20:0] cfg_data;
	logic start;
	logic busy;
	logic [1:0] cmd;
	logic [31:0] seg_handle;
	logic [15:0] seg_len;
	logic [20:0] num_bytes;
	logic [31:0] seq_num;
	logic result_strobe;
	logic [2:0] status;
	logic [31:0] frag_handle;
	logic [15:0] frag_offset;
	logic [20:0] frag_len;
	logic last;
	logic [31:0] head_sequence;
	logic [20:0] buffered_bytes;
	logic [20:0] available_bytes;

	segment_ring_scoreboard ring_model;
	longint cycle_count;
	bit [31:0] cur_seq;

	tcp_send_segment_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.seg_handle(seg_handle),
		.seg_len(seg_len),
		.num_bytes(num_bytes),
		.seq_num(seq_num),
		.result_strobe(result_strobe),
		.status(status),
		.frag_handle(frag_handle),
		.frag_offset(frag_offset),
		.frag_len(frag_len),
		.last(last),
		.head_sequence(head_sequence),
		.buffered_bytes(buffered_bytes),
		.available_bytes(available_bytes)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("tcp_send_segment_buffer_tb failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		seg_result_t r;
		if (arst_n && result_strobe) begin
			r.status = status;
			r.handle = frag_handle;
			r.offset = frag_offset;
			r.len = frag_len;
			r.last = last;
			r.head = head_sequence;
			r.held = buffered_bytes;
			r.avail = available_bytes;
			ring_model.check_result(r);
		end
	end

	task automatic send_command(logic [1:0] op, logic [31:0] h, logic [15:0] l,
		logic [20:0] n, logic [31:0] s);
		cmd_t c;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		cmd <= op;
		seg_handle <= h;
		seg_len <= l;
		num_bytes <= n;
		seq_num <= s;
		c.cmd = op;
		c.seg_handle = h;
		c.seg_len = l;
		c.num_bytes = n;
		c.seq_num = s;
		@(posedge clk);
		while (busy) @(posedge clk);
		ring_model.note_command(c);
	endtask

	task automatic drain();
		start <= 0;
		while (ring_model.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_limit(logic [20:0] v);
		drain();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		ring_model.limit = v;
	endtask

	task automatic random_command();
		int pick;
		bit [31:0] tail;
		bit [31:0] s;
		pick = $urandom_range(0, 99);
		tail = ring_model.head_seq + ring_model.held;
		if (pick < 40) begin
			send_command(CMD_ADD, $urandom, 16'(($urandom_range(0, 9) == 0) ? $urandom :
				$urandom_range(0, 3000)), 21'($urandom), $urandom);
		end else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: s = $urandom;
				1: s = tail - $urandom_range(0, 1) * $urandom_range(0, 20);
				default: s = ring_model.head_seq + $urandom_range(0, ring_model.held + 4);
			endcase
			send_command(CMD_COPY, $urandom, 16'($urandom), 21'(($urandom_range(0, 4) == 0) ?
				$urandom : $urandom_range(0, 8000)), s);
		end else if (pick < 93) begin
			s = ($urandom_range(0, 9) == 0) ? $urandom :
				ring_model.head_seq + $urandom_range(0, ring_model.held / 2 + 2);
			send_command(CMD_DISCARD, $urandom, 16'($urandom), 21'($urandom), s);
		end else begin
			send_command(CMD_SET_HEAD, $urandom, 16'($urandom), 21'($urandom),
				(ring_model.count == 0) ? $urandom : ring_model.head_seq);
		end
	endtask

	initial begin
		ring_model = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		start = 0;
		cmd = CMD_ADD;
		seg_handle = 0;
		seg_len = 0;
		num_bytes = 0;
		seq_num = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_command(CMD_COPY, 0, 0, 21'd100, 0);
		send_command(CMD_COPY, 0, 0, 21'd100, 32'd5);
		send_command(CMD_ADD, 32'hFFFFFFFF, 16'd0, 0, 0);
		send_command(CMD_ADD, 32'hFFFFFFFF, 16'hFFFF, 0, 0);
		send_command(CMD_SET_HEAD, 0, 0, 0, 32'hFFFFFFF0);
		send_command(CMD_COPY, 0, 0, 21'h1FFFFF, 32'hFFFFFFF0);
		for (int i = 0; i < 17; i++)
			send_command(CMD_ADD, 32'hA000 + i, 16'd100, 0, 0);
		send_command(CMD_COPY, 0, 0, 21'h1FFFFF, 32'hFFFFFFF0);
		send_command(CMD_COPY, 0, 0, 21'd10, 32'hFFFFFFE0);
		send_command(CMD_COPY, 0, 0, 21'd50, 32'hFFFFFFF0 + 32'd150);
		send_command(CMD_DISCARD, 0, 0, 0, 32'hFFFFFFE0);
		send_command(CMD_DISCARD, 0, 0, 0, 32'hFFFFFFF0 + 32'd100);
		send_command(CMD_DISCARD, 0, 0, 0, 32'hFFFFFFF0 + 32'd130);
		send_command(CMD_DISCARD, 0, 0, 0, 32'h7000_0000);
		send_command(CMD_COPY, 0, 0, 21'd0, 32'h7000_0000);

		write_limit(21'd0);
		send_command(CMD_ADD, 32'h1, 16'd1, 0, 0);
		send_command(CMD_ADD, 32'h1, 16'd0, 0, 0);
		write_limit(21'h1FFFFF);
		for (int i = 0; i < 230; i++) begin
			if (i == 80)
				write_limit(21'd4000);
			if (i == 120)
				drain();
			if (i == 160)
				write_limit(21'd1048576);
			random_command();
		end
		write_limit(21'd32768);
		drain();
		if (ring_model.errors == 0 && ring_model.pending.size() == 0)
			$display("tcp_send_segment_buffer_tb passed");
		else
			$display("tcp_send_segment_buffer_tb failed");
		$finish;
	end

endmodule

@@ tcp_send_segment_buffer.f @@
sv/tssb_pkg.sv
sv/tssb_ram.sv
sv/tssb_front.sv
sv/tssb_back.sv
sv/tcp_send_segment_buffer.sv
verif/tcp_send_segment_buffer_tb.sv
